[rtl/cdf_pkg.sv]
// ----------------------------------------------------------------------------
// cdf_pkg
// shared types and constants of the centroid defuzzifier
// ----------------------------------------------------------------------------
package cdf_pkg;

    localparam int SAMPLE_W = 16;  // point value and crisp result width
    localparam int GRADE_W  = 16;  // membership grade width
    localparam int WGT_W    = GRADE_W + 1;                  // upper plus lower grade
    localparam int PROD_W   = SAMPLE_W + WGT_W;             // signed value times weight
    localparam int WSUM_W   = 51;  // weighted value sum
    localparam int WTOT_W   = 28;  // weight sum
    localparam int CNT_W    = $clog2(WSUM_W);

    localparam logic [CNT_W-1:0]  DIV_LAST_STEP = CNT_W'(WSUM_W - 1);
    localparam logic [WSUM_W-1:0] MAG_POS_MAX   = WSUM_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic [WSUM_W-1:0] MAG_NEG_MAX   = WSUM_W'(1 << (SAMPLE_W - 1));
    localparam logic [SAMPLE_W-1:0] SAT_POS     = SAMPLE_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic [SAMPLE_W-1:0] SAT_NEG     = SAMPLE_W'(1 << (SAMPLE_W - 1));

    localparam logic MODE_TYPE1 = 1'b0;
    localparam logic MODE_NT    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DIV_START,
        ST_DIV_WAIT
    } t_seq_state;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_FIX,
        DIV_DONE
    } t_div_state;

    typedef struct packed {
        logic capture;
        logic mul;
        logic acc;
        logic clear;
    } t_mac_ctl;

    typedef struct packed {
        logic start;
        logic ack;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

[rtl/centroid_defuzzifier.sv]
// a point that is not last runs capture, multiply and accumulate in turn, and o_ready
// stays low until it is done, so a new point waits for the one before
// a last point adds the divide: 51 one-bit restoring steps plus load, fix and hand-off,
//   and the next point is taken only after the result is handed to the output register
// reset: synchronous active low, clears mode, both sums, sequencer and output valid
// ----------------------------------------------------------------------------
// centroid_defuzzifier
// streaming centroid defuzzifier, type-1 or interval type-2 nt averaging
// ----------------------------------------------------------------------------
module centroid_defuzzifier (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration: mode register
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_wdata,
    // input word channel
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [cdf_pkg::SAMPLE_W-1:0]   i_point_value,
    input  logic        [cdf_pkg::GRADE_W-1:0]    i_upper_membership,
    input  logic        [cdf_pkg::GRADE_W-1:0]    i_lower_membership,
    input  logic                                  i_last_point,
    // result word channel
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [cdf_pkg::SAMPLE_W-1:0]   o_crisp_value,
    output logic                                  o_zero_weight
);
    import cdf_pkg::*;

    t_seq_state                r_state, n_state;
    logic                      r_mode;
    logic                      r_last;
    logic                      r_out_valid, n_out_valid;
    logic signed [SAMPLE_W-1:0] r_crisp;
    logic                      r_zero;
    logic                      w_accept;
    logic                      w_load;
    t_mac_ctl                  w_mac_ctl;
    t_div_ctl                  w_div_ctl;
    t_div_sts                  w_div_sts;
    logic signed [WSUM_W-1:0]  w_wsum;
    logic        [WTOT_W-1:0]  w_wtot;
    logic signed [SAMPLE_W-1:0] w_quot;
    logic                      w_quot_zero;

    // mode register; the user must write it only between sets, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_TYPE1;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;

    // result register is free when empty or being drained this cycle
    assign w_load = (r_state == ST_DIV_WAIT) && w_div_sts.done
                 && (!r_out_valid || i_ready);

    // sequencer: capture -> multiply -> accumulate, last point runs the divide
    always_comb begin
        n_state           = r_state;
        w_mac_ctl         = '0;
        w_div_ctl         = '0;
        w_mac_ctl.capture = w_accept;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                w_mac_ctl.mul = 1'b1;
                n_state       = ST_ACC;
            end
            ST_ACC: begin
                w_mac_ctl.acc = 1'b1;
                n_state       = r_last ? ST_DIV_START : ST_IDLE;
            end
            ST_DIV_START: begin
                // divider takes the sums, then they clear for the next set
                w_div_ctl.start = 1'b1;
                w_mac_ctl.clear = 1'b1;
                n_state         = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (w_load) begin
                    w_div_ctl.ack = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_last <= i_last_point;
        end
    end

    // output register: holds a finished word while the next set streams in
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_crisp <= w_quot;
            r_zero  <= w_quot_zero;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_crisp_value = r_crisp;
    assign o_zero_weight = r_zero;

    cdf_mac u_mac (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctl              (w_mac_ctl),
        .i_mode             (r_mode),
        .i_point_value      (i_point_value),
        .i_upper_membership (i_upper_membership),
        .i_lower_membership (i_lower_membership),
        .o_wsum             (w_wsum),
        .o_wtot             (w_wtot)
    );

    cdf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (w_wsum),
        .i_den   (w_wtot),
        .o_sts   (w_div_sts),
        .o_quot  (w_quot),
        .o_zero  (w_quot_zero)
    );

    // no new point is taken while the divider is working
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.busy |-> !o_ready)
        else $error("point accepted during divide");

    // a point that is accepted keeps the block busy for the multiply cycle
    a_accept_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("back to back accept");

    // a finished divide lands in the result register
    a_load_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_valid && !w_div_sts.done))
        else $error("divide result not handed to output");

    // the sums start every set from zero
    a_sums_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_ctl.start |=> (w_wsum == '0 && w_wtot == '0))
        else $error("sums not cleared after last point");

endmodule

[rtl/cdf_mac.sv]
// ----------------------------------------------------------------------------
// cdf_mac
// weight select, registered multiply and the two running sums
// ----------------------------------------------------------------------------
module cdf_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  cdf_pkg::t_mac_ctl                     i_ctl,
    input  logic                                  i_mode,
    input  logic signed [cdf_pkg::SAMPLE_W-1:0]   i_point_value,
    input  logic        [cdf_pkg::GRADE_W-1:0]    i_upper_membership,
    input  logic        [cdf_pkg::GRADE_W-1:0]    i_lower_membership,
    output logic signed [cdf_pkg::WSUM_W-1:0]     o_wsum,
    output logic        [cdf_pkg::WTOT_W-1:0]     o_wtot
);
    import cdf_pkg::*;

    logic signed [SAMPLE_W-1:0] r_value;
    logic        [WGT_W-1:0]    r_weight;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [WSUM_W-1:0]   r_wsum, n_wsum;
    logic        [WTOT_W-1:0]   r_wtot, n_wtot;
    logic        [WGT_W-1:0]    w_weight;
    logic signed [PROD_W:0]     w_prod_full;

    // nt mode: upper plus lower, the one half cancels in the ratio
    assign w_weight = {1'b0, i_upper_membership}
                    + ((i_mode == MODE_NT) ? {1'b0, i_lower_membership} : '0);

    assign w_prod_full = r_value * $signed({1'b0, r_weight});

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_value  <= i_point_value;
            r_weight <= w_weight;
        end
        if (i_ctl.mul) begin
            r_prod <= w_prod_full[PROD_W-1:0];
        end
    end

    always_comb begin
        n_wsum = r_wsum;
        n_wtot = r_wtot;
        if (i_ctl.clear) begin
            n_wsum = '0;
            n_wtot = '0;
        end else if (i_ctl.acc) begin
            n_wsum = r_wsum + WSUM_W'(r_prod);
            n_wtot = r_wtot + WTOT_W'(r_weight);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsum <= '0;
            r_wtot <= '0;
        end else begin
            r_wsum <= n_wsum;
            r_wtot <= n_wtot;
        end
    end

    assign o_wsum = r_wsum;
    assign o_wtot = r_wtot;

endmodule

[rtl/cdf_div.sv]
// ----------------------------------------------------------------------------
// cdf_div
// restoring divider, one quotient bit a cycle, with sign fix and saturation
// ----------------------------------------------------------------------------
module cdf_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  cdf_pkg::t_div_ctl                     i_ctl,
    input  logic signed [cdf_pkg::WSUM_W-1:0]     i_num,
    input  logic        [cdf_pkg::WTOT_W-1:0]     i_den,
    output cdf_pkg::t_div_sts                     o_sts,
    output logic signed [cdf_pkg::SAMPLE_W-1:0]   o_quot,
    output logic                                  o_zero
);
    import cdf_pkg::*;

    t_div_state          r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [WSUM_W-1:0]   r_quo, n_quo;
    logic [WTOT_W-1:0]   r_rem, n_rem;
    logic [WTOT_W-1:0]   r_den, n_den;
    logic                r_neg, n_neg;
    logic [SAMPLE_W-1:0] r_res, n_res;
    logic                r_zero, n_zero;
    logic [WTOT_W:0]     w_shift;
    logic [WTOT_W:0]     w_diff;
    logic [WSUM_W-1:0]   w_neg_quo;
    logic [SAMPLE_W-1:0] w_sat;

    assign w_shift   = {r_rem, r_quo[WSUM_W-1]};
    assign w_diff    = w_shift - {1'b0, r_den};
    assign w_neg_quo = -r_quo;

    always_comb begin
        if (r_neg) begin
            w_sat = (r_quo > MAG_NEG_MAX) ? SAT_NEG : w_neg_quo[SAMPLE_W-1:0];
        end else begin
            w_sat = (r_quo > MAG_POS_MAX) ? SAT_POS : r_quo[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_den   = r_den;
        n_neg   = r_neg;
        n_res   = r_res;
        n_zero  = r_zero;
        unique case (r_state)
            DIV_IDLE: begin
                if (i_ctl.start) begin
                    n_den = i_den;
                    n_neg = i_num[WSUM_W-1];
                    n_quo = i_num[WSUM_W-1] ? -i_num : i_num;
                    n_rem = '0;
                    n_cnt = DIV_LAST_STEP;
                    if (i_den == '0) begin
                        n_res   = '0;
                        n_zero  = 1'b1;
                        n_state = DIV_DONE;
                    end else begin
                        n_state = DIV_RUN;
                    end
                end
            end
            DIV_RUN: begin
                n_rem = w_diff[WTOT_W] ? w_shift[WTOT_W-1:0] : w_diff[WTOT_W-1:0];
                n_quo = {r_quo[WSUM_W-2:0], ~w_diff[WTOT_W]};
                if (r_cnt == '0) begin
                    n_state = DIV_FIX;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            DIV_FIX: begin
                n_res   = w_sat;
                n_zero  = 1'b0;
                n_state = DIV_DONE;
            end
            DIV_DONE: begin
                if (i_ctl.ack) begin
                    n_state = DIV_IDLE;
                end
            end
            default: n_state = DIV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_neg  <= n_neg;
        r_res  <= n_res;
        r_zero <= n_zero;
    end

    assign o_sts.busy = (r_state != DIV_IDLE);
    assign o_sts.done = (r_state == DIV_DONE);
    assign o_quot     = r_res;
    assign o_zero     = r_zero;

    // zero divisor result is always a forced zero
    a_zero_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_sts.done && o_zero) |-> (o_quot == '0))
        else $error("zero weight result not forced to zero");

    // a start is only issued while the unit is free
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> (r_state == DIV_IDLE))
        else $error("divider started while busy");

    // the iteration count only walks down while running
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == DIV_RUN && r_cnt != '0) |=> (r_cnt == $past(r_cnt) - 1'b1))
        else $error("divider step count skipped");

endmodule
